// ===== rtl/i2da_pkg.sv =====
// Package with the sizes, character codes and sequencer states of the decimal text converter.
`default_nettype none
package i2da_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_WIDTH = 32;
  // Decimal digits needed for 2^VALUE_WIDTH - 1 (1233/4096 is close to log10 of 2).
  localparam int DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W = DIGITS * 4;
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W = $clog2(DIGITS + 1);
  localparam int CHAR_W = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/int_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter with its sequencer and output register.
// Sequencing: after acceptance, the conversion state takes one input bit per step through the shared
// digit-adjust-and-shift unit, the skip state then drops leading zero digits, and the sign (if any) and
// the digits follow; characters are sent one per cycle while the output is not stalled by out_ready.
// Flow: ready only while idle, so a new value is not taken until the last character has been issued.
// Reset: rst, synchronous, returns the sequencer to idle and clears out_valid.
`default_nettype none
module int_to_decimal_ascii (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [i2da_pkg::IN_WIDTH-1:0] value,
  input  wire logic                         is_signed,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [i2da_pkg::CHAR_W-1:0]  character,
  output logic                              last
);

  i2da_pkg::state_t state, state_next;

  logic [i2da_pkg::VALUE_WIDTH-1:0] mag, mag_next;
  logic [i2da_pkg::BCD_W-1:0]       bcd, bcd_next;
  logic [i2da_pkg::BCD_W-1:0]       bcd_shifted;
  logic [i2da_pkg::BIT_CNT_W-1:0]   bit_cnt, bit_cnt_next;
  logic [i2da_pkg::DIG_CNT_W-1:0]   dig_cnt, dig_cnt_next;
  logic                             neg, neg_next;
  logic                             out_valid_next;
  logic [i2da_pkg::CHAR_W-1:0]      character_next;
  logic                             last_next;
  logic [i2da_pkg::VALUE_WIDTH-1:0] raw;
  logic [3:0]                       top_digit;
  logic                             out_free;

  assign raw = i2da_pkg::VALUE_WIDTH'(value);
  assign top_digit = bcd[i2da_pkg::BCD_W-1 -: 4];
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == i2da_pkg::ST_IDLE);

  i2da_dabble u_dabble (
    .bcd         (bcd),
    .shift_bit   (mag[i2da_pkg::VALUE_WIDTH-1]),
    .bcd_shifted (bcd_shifted)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= i2da_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    bcd       <= bcd_next;
    bit_cnt   <= bit_cnt_next;
    dig_cnt   <= dig_cnt_next;
    neg       <= neg_next;
    character <= character_next;
    last      <= last_next;
  end

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    bcd_next       = bcd;
    bit_cnt_next   = bit_cnt;
    dig_cnt_next   = dig_cnt;
    neg_next       = neg;
    character_next = character;
    last_next      = last;
    out_valid_next = out_valid && !out_ready;

    case (state)
      i2da_pkg::ST_IDLE: begin
        if (in_valid) begin
          neg_next = is_signed && raw[i2da_pkg::VALUE_WIDTH-1];
          // The most negative value negates to itself, which read unsigned is its magnitude.
          mag_next = neg_next ? (~raw + i2da_pkg::VALUE_WIDTH'(1)) : raw;
          bcd_next = '0;
          bit_cnt_next = '0;
          state_next = i2da_pkg::ST_CONV;
        end
      end
      i2da_pkg::ST_CONV: begin
        bcd_next = bcd_shifted;
        mag_next = {mag[i2da_pkg::VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_next = bit_cnt + i2da_pkg::BIT_CNT_W'(1);
        if (bit_cnt == i2da_pkg::BIT_CNT_W'(i2da_pkg::VALUE_WIDTH - 1)) begin
          dig_cnt_next = i2da_pkg::DIG_CNT_W'(i2da_pkg::DIGITS);
          state_next = i2da_pkg::ST_SKIP;
        end
      end
      i2da_pkg::ST_SKIP: begin
        // Drop leading zero digits but always keep the last one, so zero prints as '0'.
        if (top_digit == 4'd0 && dig_cnt > i2da_pkg::DIG_CNT_W'(1)) begin
          bcd_next = {bcd[i2da_pkg::BCD_W-5:0], 4'd0};
          dig_cnt_next = dig_cnt - i2da_pkg::DIG_CNT_W'(1);
        end else if (neg) begin
          state_next = i2da_pkg::ST_SIGN;
        end else begin
          state_next = i2da_pkg::ST_DIGIT;
        end
      end
      i2da_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          character_next = i2da_pkg::CHAR_MINUS;
          last_next = 1'b0;
          state_next = i2da_pkg::ST_DIGIT;
        end
      end
      i2da_pkg::ST_DIGIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          character_next = i2da_pkg::CHAR_ZERO + {2'b00, top_digit};
          last_next = (dig_cnt == i2da_pkg::DIG_CNT_W'(1));
          bcd_next = {bcd[i2da_pkg::BCD_W-5:0], 4'd0};
          dig_cnt_next = dig_cnt - i2da_pkg::DIG_CNT_W'(1);
          if (dig_cnt == i2da_pkg::DIG_CNT_W'(1)) begin
            state_next = i2da_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = i2da_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/i2da_dabble.sv =====
// One double-dabble step: add three to each BCD digit above four, then shift in one bit.
`default_nettype none
module i2da_dabble (
  input  wire logic [i2da_pkg::BCD_W-1:0] bcd,
  input  wire logic                       shift_bit,
  output logic      [i2da_pkg::BCD_W-1:0] bcd_shifted
);

  logic [i2da_pkg::BCD_W-1:0] adjusted;

  always_comb begin
    for (int d = 0; d < i2da_pkg::DIGITS; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        adjusted[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end else begin
        adjusted[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
  end

  assign bcd_shifted = {adjusted[i2da_pkg::BCD_W-2:0], shift_bit};

endmodule
`default_nettype wire
